// ===== hdl/i2cswr_pkg.sv =====
package i2cswr_pkg;

  localparam int unsigned AddrWidth = 7;
  localparam int unsigned ByteWidth = 8;
  localparam int unsigned BitCntWidth = 3;

  localparam logic [AddrWidth-1:0] OwnAddressReset = 7'h7A;
  localparam logic [BitCntWidth-1:0] LastBitIdx = 3'd7;

  localparam logic StatusSuccess = 1'b0;
  localparam logic StatusNotTarget = 1'b1;

  typedef enum logic [2:0] {
    PH_WAIT_START,
    PH_ADDR,
    PH_ACK1_FALL,
    PH_ACK1_RISE,
    PH_DATA,
    PH_ACK2_FALL,
    PH_ACK2_RISE,
    PH_WAIT_STOP
  } phase_t;

  typedef struct packed {
    logic scl;
    logic sda;
  } sample_t;

  typedef struct packed {
    logic                 sda_out;
    logic                 done_res;
    logic                 status;
    logic [AddrWidth-1:0] address;
    logic [ByteWidth-1:0] data;
  } result_t;

endpackage

// ===== hdl/i2c_slave_write_receiver.sv =====
// A sample accepted at the input gives its result through the input register, then
// the result register.
// Throughput: one sample per cycle unless the output stalls; the input register and
// the result register let one new sample in while a finished result waits to be taken.
// Reset (synchronous, rst_n low): both registers empty, waiting for START, bus history idle
// high, line released, own address 0x7A.
module i2c_slave_write_receiver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // scl_in [0], sda_in [1], zeros [7:2]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // sda_out [0], address [7:1], data [15:8]
  output logic        out_tlast,
  output logic        out_tuser,  // status [0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data
);

  logic                              in_valid_r, in_valid_nxt;
  i2cswr_pkg::sample_t               in_sample_r;
  logic                              out_valid_r, out_valid_nxt;
  i2cswr_pkg::result_t               out_res_r;
  logic [i2cswr_pkg::AddrWidth-1:0]  own_addr_r;
  i2cswr_pkg::result_t               core_res;
  logic                              out_load, in_adv, in_acc;

  assign out_load  = !out_valid_r || out_tready;
  assign in_adv    = in_valid_r && out_load;
  assign in_tready = !in_valid_r || out_load;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign in_valid_nxt  = in_acc ? 1'b1 : (in_adv ? 1'b0 : in_valid_r);
  assign out_valid_nxt = out_load ? in_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      own_addr_r  <= i2cswr_pkg::OwnAddressReset;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) own_addr_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_sample_r.scl <= in_tdata[0];
      in_sample_r.sda <= in_tdata[1];
    end
    if (in_adv) out_res_r <= core_res;
  end

  i2cswr_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (in_adv),
    .sample      (in_sample_r),
    .own_address (own_addr_r),
    .result      (core_res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.data, out_res_r.address, out_res_r.sda_out};
  assign out_tlast  = out_res_r.done_res;
  assign out_tuser  = out_res_r.status;

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> out_tdata[0])
    else $error("line held low on a finished transaction");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> (!out_tuser && out_tdata[15:1] == '0))
    else $error("result fields set without a finished transaction");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast && out_tuser) |-> out_tdata[15:8] == '0)
    else $error("data reported for a foreign address");

  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !out_load) |=> (in_valid_r && $stable(in_sample_r)))
    else $error("stalled sample lost from the input register");

endmodule

// ===== hdl/i2cswr_core.sv =====
module i2cswr_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              step,
  input  i2cswr_pkg::sample_t               sample,
  input  logic [i2cswr_pkg::AddrWidth-1:0]  own_address,
  output i2cswr_pkg::result_t               result
);

  i2cswr_pkg::phase_t phase_r, phase_nxt;
  logic [i2cswr_pkg::BitCntWidth-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [i2cswr_pkg::ByteWidth-1:0]   shift_r, shift_nxt;
  logic [i2cswr_pkg::AddrWidth-1:0]   held_addr_r, held_addr_nxt;
  logic                               last_scl_r, last_sda_r;
  logic                               drive_r, drive_nxt;

  logic                               rise, fall, start_cond, stop_cond, last_bit;
  logic [i2cswr_pkg::ByteWidth-1:0]   shifted;

  assign rise       = !last_scl_r && sample.scl;
  assign fall       = last_scl_r && !sample.scl;
  assign start_cond = sample.scl && last_scl_r && last_sda_r && !sample.sda;
  assign stop_cond  = sample.scl && last_scl_r && !last_sda_r && sample.sda;
  assign shifted    = {shift_r[i2cswr_pkg::ByteWidth-2:0], sample.sda};
  assign last_bit   = (bit_cnt_r == i2cswr_pkg::LastBitIdx);

  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      i2cswr_pkg::PH_WAIT_START: begin
        if (start_cond) phase_nxt = i2cswr_pkg::PH_ADDR;
      end
      i2cswr_pkg::PH_ADDR: begin
        if (rise && last_bit) begin
          if (shifted[i2cswr_pkg::ByteWidth-1:1] == own_address) begin
            phase_nxt = i2cswr_pkg::PH_ACK1_FALL;
          end else begin
            phase_nxt = i2cswr_pkg::PH_WAIT_START;
          end
        end
      end
      i2cswr_pkg::PH_ACK1_FALL: begin
        if (fall) phase_nxt = i2cswr_pkg::PH_ACK1_RISE;
      end
      i2cswr_pkg::PH_ACK1_RISE: begin
        if (rise) phase_nxt = i2cswr_pkg::PH_DATA;
      end
      i2cswr_pkg::PH_DATA: begin
        if (rise && last_bit) phase_nxt = i2cswr_pkg::PH_ACK2_FALL;
      end
      i2cswr_pkg::PH_ACK2_FALL: begin
        if (fall) phase_nxt = i2cswr_pkg::PH_ACK2_RISE;
      end
      i2cswr_pkg::PH_ACK2_RISE: begin
        if (rise) phase_nxt = i2cswr_pkg::PH_WAIT_STOP;
      end
      i2cswr_pkg::PH_WAIT_STOP: begin
        if (stop_cond) phase_nxt = i2cswr_pkg::PH_WAIT_START;
      end
      default: phase_nxt = i2cswr_pkg::PH_WAIT_START;
    endcase
  end

  always_comb begin
    bit_cnt_nxt      = bit_cnt_r;
    shift_nxt        = shift_r;
    held_addr_nxt    = held_addr_r;
    drive_nxt        = drive_r;
    result.done_res  = 1'b0;
    result.status    = i2cswr_pkg::StatusSuccess;
    result.address   = '0;
    result.data      = '0;
    unique case (phase_r)
      i2cswr_pkg::PH_WAIT_START: begin
        if (start_cond) begin
          shift_nxt   = '0;
          bit_cnt_nxt = '0;
        end
      end
      i2cswr_pkg::PH_ADDR: begin
        if (rise) begin
          shift_nxt   = shifted;
          bit_cnt_nxt = bit_cnt_r + 1'b1;
          if (last_bit) begin
            held_addr_nxt = shifted[i2cswr_pkg::ByteWidth-1:1];
            bit_cnt_nxt   = '0;
            if (shifted[i2cswr_pkg::ByteWidth-1:1] != own_address) begin
              result.done_res = 1'b1;
              result.status   = i2cswr_pkg::StatusNotTarget;
              result.address  = shifted[i2cswr_pkg::ByteWidth-1:1];
            end
          end
        end
      end
      i2cswr_pkg::PH_ACK1_FALL, i2cswr_pkg::PH_ACK2_FALL: begin
        if (fall) drive_nxt = 1'b0;
      end
      i2cswr_pkg::PH_ACK1_RISE: begin
        if (rise) begin
          drive_nxt   = 1'b1;
          shift_nxt   = '0;
          bit_cnt_nxt = '0;
        end
      end
      i2cswr_pkg::PH_DATA: begin
        if (rise) begin
          shift_nxt   = shifted;
          bit_cnt_nxt = last_bit ? '0 : bit_cnt_r + 1'b1;
        end
      end
      i2cswr_pkg::PH_ACK2_RISE: begin
        if (rise) drive_nxt = 1'b1;
      end
      i2cswr_pkg::PH_WAIT_STOP: begin
        if (stop_cond) begin
          result.done_res = 1'b1;
          result.status   = i2cswr_pkg::StatusSuccess;
          result.address  = held_addr_r;
          result.data     = shift_r;
        end
      end
      default: begin
      end
    endcase
    result.sda_out = drive_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= i2cswr_pkg::PH_WAIT_START;
      bit_cnt_r   <= '0;
      shift_r     <= '0;
      held_addr_r <= '0;
      last_scl_r  <= 1'b1;
      last_sda_r  <= 1'b1;
      drive_r     <= 1'b1;
    end else if (step) begin
      phase_r     <= phase_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      shift_r     <= shift_nxt;
      held_addr_r <= held_addr_nxt;
      last_scl_r  <= sample.scl;
      last_sda_r  <= sample.sda;
      drive_r     <= drive_nxt;
    end
  end

  // The line is only held low while waiting for the rising edge that ends an acknowledge.
  assert property (@(posedge clk) disable iff (!rst_n)
    !drive_r == (phase_r == i2cswr_pkg::PH_ACK1_RISE || phase_r == i2cswr_pkg::PH_ACK2_RISE))
    else $error("drive level out of step with phase");

  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == i2cswr_pkg::PH_WAIT_START || phase_r == i2cswr_pkg::PH_WAIT_STOP) |->
      bit_cnt_r == '0)
    else $error("bit counter not cleared outside a byte");

endmodule

// ===== tb/sv/i2c_write_checker.sv =====
`timescale 1ns / 100ps

module i2c_write_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic        out_tlast,
  input  logic        out_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [6:0]  cfg_data,
  output int unsigned fail_count,
  output int unsigned outstanding
);

  i2cswr_pkg::phase_t                bus_phase;
  logic [3:0]                        bits_seen;
  logic [i2cswr_pkg::ByteWidth-1:0]  rx_shift;
  logic [i2cswr_pkg::AddrWidth-1:0]  rx_addr;
  logic [i2cswr_pkg::AddrWidth-1:0]  own_addr;
  logic                              hist_scl;
  logic                              hist_sda;
  logic                              sda_drive;

  i2cswr_pkg::result_t pending_results[$];

  initial fail_count = 0;

  task automatic clear_bus_state();
    bus_phase = i2cswr_pkg::PH_WAIT_START;
    bits_seen = '0;
    rx_shift  = '0;
    rx_addr   = '0;
    own_addr  = i2cswr_pkg::OwnAddressReset;
    hist_scl  = 1'b1;
    hist_sda  = 1'b1;
    sda_drive = 1'b1;
  endtask

  task automatic predict_bus_sample(input logic scl, input logic sda);
    i2cswr_pkg::result_t res;
    logic                rise;
    logic                fall;
    res  = '0;
    rise = !hist_scl && scl;
    fall = hist_scl && !scl;
    case (bus_phase)
      i2cswr_pkg::PH_ADDR: begin
        if (rise) begin
          rx_shift  = {rx_shift[i2cswr_pkg::ByteWidth-2:0], sda};
          bits_seen = bits_seen + 4'd1;
          if (bits_seen >= i2cswr_pkg::ByteWidth) begin
            // The lowest bit is the read/write flag, which a write-only slave ignores.
            rx_addr   = rx_shift[i2cswr_pkg::ByteWidth-1:1];
            bits_seen = '0;
            if (rx_addr == own_addr) begin
              bus_phase = i2cswr_pkg::PH_ACK1_FALL;
            end else begin
              res.done_res = 1'b1;
              res.status   = i2cswr_pkg::StatusNotTarget;
              res.address  = rx_addr;
              bus_phase    = i2cswr_pkg::PH_WAIT_START;
            end
          end
        end
      end
      i2cswr_pkg::PH_ACK1_FALL, i2cswr_pkg::PH_ACK2_FALL: begin
        if (fall) begin
          sda_drive = 1'b0;
          bus_phase = (bus_phase == i2cswr_pkg::PH_ACK1_FALL) ? i2cswr_pkg::PH_ACK1_RISE
                                                               : i2cswr_pkg::PH_ACK2_RISE;
        end
      end
      i2cswr_pkg::PH_ACK1_RISE: begin
        if (rise) begin
          sda_drive = 1'b1;
          rx_shift  = '0;
          bits_seen = '0;
          bus_phase = i2cswr_pkg::PH_DATA;
        end
      end
      i2cswr_pkg::PH_DATA: begin
        if (rise) begin
          rx_shift  = {rx_shift[i2cswr_pkg::ByteWidth-2:0], sda};
          bits_seen = bits_seen + 4'd1;
          if (bits_seen >= i2cswr_pkg::ByteWidth) begin
            bits_seen = '0;
            bus_phase = i2cswr_pkg::PH_ACK2_FALL;
          end
        end
      end
      i2cswr_pkg::PH_ACK2_RISE: begin
        if (rise) begin
          sda_drive = 1'b1;
          bus_phase = i2cswr_pkg::PH_WAIT_STOP;
        end
      end
      i2cswr_pkg::PH_WAIT_STOP: begin
        if (scl && hist_scl && !hist_sda && sda) begin
          res.done_res = 1'b1;
          res.status   = i2cswr_pkg::StatusSuccess;
          res.address  = rx_addr;
          res.data     = rx_shift;
          bus_phase    = i2cswr_pkg::PH_WAIT_START;
        end
      end
      default: begin
        if (scl && hist_scl && hist_sda && !sda) begin
          rx_shift  = '0;
          bits_seen = '0;
          bus_phase = i2cswr_pkg::PH_ADDR;
        end else begin
          bus_phase = i2cswr_pkg::PH_WAIT_START;
        end
      end
    endcase
    hist_scl    = scl;
    hist_sda    = sda;
    res.sda_out = sda_drive;
    pending_results.push_back(res);
  endtask

  task automatic check_result();
    i2cswr_pkg::result_t want;
    i2cswr_pkg::result_t got;
    got.sda_out  = out_tdata[0];
    got.address  = out_tdata[7:1];
    got.data     = out_tdata[15:8];
    got.done_res = out_tlast;
    got.status   = out_tuser;
    if (pending_results.size() == 0) begin
      $error("result arrived with nothing outstanding");
      fail_count++;
    end else begin
      want = pending_results.pop_front();
      if (got.sda_out !== want.sda_out) begin
        $error("sda_out mismatch: expected %0d, got %0d", want.sda_out, got.sda_out);
        fail_count++;
      end
      if (got.done_res !== want.done_res) begin
        $error("done_res mismatch: expected %0d, got %0d", want.done_res, got.done_res);
        fail_count++;
      end
      if (got.status !== want.status) begin
        $error("status mismatch: expected %0d, got %0d", want.status, got.status);
        fail_count++;
      end
      if (got.address !== want.address) begin
        $error("address mismatch: expected %0h, got %0h", want.address, got.address);
        fail_count++;
      end
      if (got.data !== want.data) begin
        $error("data mismatch: expected %0h, got %0h", want.data, got.data);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_bus_state();
      pending_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        own_addr = cfg_data;
      end
      if (out_tvalid && out_tready) begin
        check_result();
      end
      if (in_tvalid && in_tready) begin
        predict_bus_sample(in_tdata[0], in_tdata[1]);
      end
    end
    outstanding = pending_results.size();
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned SampleTarget = 1350;
  localparam int unsigned PhaseCount = 6;
  localparam int unsigned CycleLimit = 600000;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [6:0]  cfg_data = '0;

  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned samples_sent = 0;
  int unsigned cycle_count = 0;
  logic        calm = 1'b0;
  logic        line_sda = 1'b1;
  logic [6:0]  bus_own_addr = i2cswr_pkg::OwnAddressReset;

  i2c_slave_write_receiver u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  i2c_write_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  initial begin
    int unsigned stall;
    forever begin
      stall = idle_len();
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  task automatic push_sample(input logic scl, input logic sda);
    int unsigned gap;
    gap = idle_len();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, sda, scl};
    do @(posedge clk); while (!in_tready);
    samples_sent++;
  endtask

  // Holds the bus lines at one level for one or more samples.
  task automatic put_lines(input logic scl, input logic sda);
    int unsigned hold;
    hold = ($urandom_range(0, 9) < 7) ? 1 : $urandom_range(2, 4);
    line_sda = sda;
    repeat (hold) push_sample(scl, sda);
  endtask

  task automatic put_noise();
    repeat ($urandom_range(3, 12)) put_lines(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  // A write frame: START, address with R/W flag, acknowledge slot, data byte,
  // acknowledge slot and STOP. Clock slot cut_slot and beyond are replaced by noise.
  task automatic send_write(input logic [6:0] addr, input logic rw, input logic [7:0] dbyte,
                            input int unsigned cut_slot);
    logic [15:0] payload;
    logic        b;
    int unsigned slot;
    int unsigned idx;
    payload = {addr, rw, dbyte};
    idx     = 16;
    put_lines(1'b1, 1'b1);
    put_lines(1'b1, 1'b0);
    put_lines(1'b0, 1'b0);
    for (slot = 0; slot < 18; slot++) begin
      if (slot == cut_slot) begin
        put_noise();
        return;
      end
      if (slot == 8 || slot == 17) begin
        b = 1'($urandom_range(0, 1));
      end else begin
        idx--;
        b = payload[idx];
      end
      put_lines(1'b0, b);
      put_lines(1'b1, b);
      // A level change while the clock is high must pass unnoticed mid-transfer.
      if ($urandom_range(0, 29) == 0) put_lines(1'b1, !b);
      put_lines(1'b0, line_sda);
    end
    put_lines(1'b0, 1'b0);
    put_lines(1'b1, 1'b0);
    put_lines(1'b1, 1'b1);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_own_address(input logic [6:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid    <= 1'b0;
    bus_own_addr = value;
  endtask

  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin
    logic [6:0]  phase_addr [PhaseCount];
    int unsigned p;
    int unsigned goal;
    int unsigned kind;
    phase_addr[0] = i2cswr_pkg::OwnAddressReset;
    phase_addr[1] = 7'h00;
    phase_addr[2] = 7'h7F;
    phase_addr[3] = 7'($urandom_range(0, 127));
    phase_addr[4] = 7'($urandom_range(0, 127));
    phase_addr[5] = i2cswr_pkg::OwnAddressReset;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Clock edges without a START, then an address that is not ours with the read flag set.
    push_sample(1'b0, 1'b0);
    push_sample(1'b0, 1'b1);
    push_sample(1'b1, 1'b0);
    push_sample(1'b1, 1'b1);
    push_sample(1'b1, 1'b0);
    for (int i = 7; i >= 0; i--) begin
      push_sample(1'b0, 1'b1);
      push_sample(1'b1, 1'b1);
    end
    push_sample(1'b1, 1'b1);

    for (p = 0; p < PhaseCount; p++) begin
      if (p != 0) begin
        in_tvalid <= 1'b0;
        wait_drained();
        write_own_address(phase_addr[p]);
      end
      calm = (p == 2);
      goal = SampleTarget * (p + 1) / PhaseCount;
      while (samples_sent < goal) begin
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
          send_write(bus_own_addr, 1'($urandom_range(0, 1)), pick_byte(), 18);
        end else if (kind < 85) begin
          send_write(7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)), pick_byte(), 18);
        end else if (kind < 95) begin
          send_write(bus_own_addr, 1'($urandom_range(0, 1)), pick_byte(),
                     $urandom_range(0, 17));
        end else begin
          put_noise();
        end
      end
    end

    calm = 1'b0;
    in_tvalid <= 1'b0;
    wait_drained();
    repeat (6) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/i2cswr_pkg.sv
hdl/i2cswr_core.sv
hdl/i2c_slave_write_receiver.sv
tb/sv/i2c_write_checker.sv
tb/sv/testbench.sv
